@@ design/rpn_pkg.sv @@
// shared types, codes and constants for the rpn stack evaluator
package rpn_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DIV_STEPS       = 48;

    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_DIVZERO   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] operand;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] top_value;
        logic               nonempty;
        logic [6:0]         depth;
    } rsp_t;

    typedef struct packed {
        logic               start;
        logic [2:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } alu_rsp_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV,
        ALU_FIN
    } alu_state_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LOAD,
        SEQ_EXEC,
        SEQ_TOP
    } seq_state_t;

endpackage

@@ design/rpn_alu.sv @@
// shared saturating arithmetic unit: add, subtract, multiply, radix-2 divide
module rpn_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::alu_req_t req,
    output rpn_pkg::alu_rsp_t rsp
);

    localparam int SW = $clog2(rpn_pkg::DIV_STEPS);

    rpn_pkg::alu_state_t state_reg, state_next;
    logic                done_reg, done_next;
    logic signed [31:0]  value_reg, value_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic [31:0]         rem_reg, rem_next;
    logic [47:0]         dvd_reg, dvd_next;
    logic [31:0]         dvs_reg, dvs_next;
    logic                neg_reg, neg_next;
    logic [SW-1:0]       cnt_reg, cnt_next;

    logic signed [32:0]  sum;
    logic [31:0]         a_mag;
    logic [31:0]         b_mag;
    logic [32:0]         shifted;
    logic                ge;
    logic [16:0]         prod_hi;

    always_comb
    begin
        a_mag   = req.a[31] ? (~req.a + 32'd1) : req.a;
        b_mag   = req.b[31] ? (~req.b + 32'd1) : req.b;
        sum     = (req.op == rpn_pkg::OP_SUB) ? ({req.a[31], req.a} - {req.b[31], req.b})
                                              : ({req.a[31], req.a} + {req.b[31], req.b});
        shifted = {rem_reg, dvd_reg[47]};
        ge      = shifted >= {1'b0, dvs_reg};
        prod_hi = prod_reg[63:47];
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            rpn_pkg::ALU_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        rpn_pkg::OP_MUL:
                        begin
                            prod_next  = req.a * req.b;
                            state_next = rpn_pkg::ALU_MUL;
                        end
                        rpn_pkg::OP_DIV:
                        begin
                            rem_next   = '0;
                            dvd_next   = {a_mag, 16'd0};
                            dvs_next   = b_mag;
                            neg_next   = req.a[31] ^ req.b[31];
                            cnt_next   = '0;
                            state_next = rpn_pkg::ALU_DIV;
                        end
                        default:
                        begin
                            if (sum[32] != sum[31])
                                value_next = sum[32] ? rpn_pkg::SAT_MIN : rpn_pkg::SAT_MAX;
                            else
                                value_next = sum[31:0];
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            rpn_pkg::ALU_MUL:
            begin
                // floor shift by 16, then clamp
                if ((&prod_hi) || !(|prod_hi))
                    value_next = prod_reg[47:16];
                else
                    value_next = prod_reg[63] ? rpn_pkg::SAT_MIN : rpn_pkg::SAT_MAX;
                done_next  = 1'b1;
                state_next = rpn_pkg::ALU_IDLE;
            end
            rpn_pkg::ALU_DIV:
            begin
                rem_next = ge ? 32'(shifted - {1'b0, dvs_reg}) : shifted[31:0];
                dvd_next = {dvd_reg[46:0], ge};
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(rpn_pkg::DIV_STEPS - 1))
                    state_next = rpn_pkg::ALU_FIN;
            end
            rpn_pkg::ALU_FIN:
            begin
                if (neg_reg)
                    value_next = (dvd_reg > 48'h0000_8000_0000) ? rpn_pkg::SAT_MIN
                                                               : (~dvd_reg[31:0] + 32'd1);
                else
                    value_next = (dvd_reg > 48'h0000_7FFF_FFFF) ? rpn_pkg::SAT_MAX
                                                               : dvd_reg[31:0];
                done_next  = 1'b1;
                state_next = rpn_pkg::ALU_IDLE;
            end
            default:
            begin
                state_next = rpn_pkg::ALU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpn_pkg::ALU_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
        neg_reg   <= neg_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

@@ design/rpn_stack_evaluator.sv @@
// rpn stack evaluator top level: stack memory, sequencer and result register
// push, clear and errors answer from idle; add/subtract, multiply and divide pass load,
// exec and the shared unit (divide: 48 radix-2 steps); divide by zero may reload the top
// busy stays low for push, clear, underflow, overflow and unknown items, so one may be accepted every cycle
// results are shown for one cycle under done and cannot be stalled
// reset empties the stack at once; stack memory contents are left undefined
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rpn_pkg::cmd_t cmd,
    output logic          done,
    output rpn_pkg::rsp_t result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic signed [31:0] mem [STACK_DEPTH];

    rpn_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic signed [31:0]  tos_reg, tos_next;
    logic [2:0]          op_reg, op_next;
    logic signed [31:0]  rd_data_reg;
    logic                done_reg, done_next;
    rpn_pkg::rsp_t       result_reg, result_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    logic               resp_fire;
    logic [2:0]         resp_status;
    logic [CW-1:0]      resp_count;
    logic signed [31:0] resp_top;

    rpn_pkg::alu_req_t alu_req;
    rpn_pkg::alu_rsp_t alu_rsp;

    rpn_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        tos_next    = tos_reg;
        op_next     = op_reg;
        wr_en       = 1'b0;
        wr_addr     = AW'(count_reg);
        wr_data     = cmd.operand;
        rd_en       = 1'b0;
        rd_addr     = AW'(count_reg - CW'(2));
        resp_fire   = 1'b0;
        resp_status = rpn_pkg::ST_OK;
        resp_count  = count_reg;
        resp_top    = tos_reg;
        alu_req     = '{start: 1'b0, op: op_reg, a: rd_data_reg, b: tos_reg};
        case (state_reg)
            rpn_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    case (cmd.opcode)
                        rpn_pkg::OP_PUSH:
                        begin
                            resp_fire = 1'b1;
                            if (count_reg == CW'(STACK_DEPTH))
                                resp_status = rpn_pkg::ST_OVERFLOW;
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                tos_next   = cmd.operand;
                                resp_count = count_reg + CW'(1);
                                resp_top   = cmd.operand;
                            end
                        end
                        rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV:
                        begin
                            if (count_reg == CW'(0))
                            begin
                                resp_fire   = 1'b1;
                                resp_status = rpn_pkg::ST_UNDERFLOW;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                resp_fire   = 1'b1;
                                resp_status = rpn_pkg::ST_UNDERFLOW;
                                count_next  = '0;
                                resp_count  = '0;
                            end
                            else if (cmd.opcode == rpn_pkg::OP_DIV && tos_reg == '0)
                            begin
                                count_next = count_reg - CW'(2);
                                if (count_reg > CW'(2))
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = AW'(count_reg - CW'(3));
                                    state_next = rpn_pkg::SEQ_TOP;
                                end
                                else
                                begin
                                    resp_fire   = 1'b1;
                                    resp_status = rpn_pkg::ST_DIVZERO;
                                    resp_count  = '0;
                                end
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                op_next    = cmd.opcode;
                                state_next = rpn_pkg::SEQ_LOAD;
                            end
                        end
                        rpn_pkg::OP_CLEAR:
                        begin
                            resp_fire  = 1'b1;
                            count_next = '0;
                            resp_count = '0;
                        end
                        default:
                        begin
                            resp_fire   = 1'b1;
                            resp_status = rpn_pkg::ST_UNKNOWN;
                        end
                    endcase
                end
            end
            rpn_pkg::SEQ_LOAD:
            begin
                alu_req.start = 1'b1;
                state_next    = rpn_pkg::SEQ_EXEC;
            end
            rpn_pkg::SEQ_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(count_reg - CW'(2));
                    wr_data    = alu_rsp.value;
                    count_next = count_reg - CW'(1);
                    tos_next   = alu_rsp.value;
                    resp_fire  = 1'b1;
                    resp_count = count_reg - CW'(1);
                    resp_top   = alu_rsp.value;
                    state_next = rpn_pkg::SEQ_IDLE;
                end
            end
            rpn_pkg::SEQ_TOP:
            begin
                tos_next    = rd_data_reg;
                resp_fire   = 1'b1;
                resp_status = rpn_pkg::ST_DIVZERO;
                resp_top    = rd_data_reg;
                state_next  = rpn_pkg::SEQ_IDLE;
            end
            default:
            begin
                state_next = rpn_pkg::SEQ_IDLE;
            end
        endcase

        done_next             = resp_fire;
        result_next.status    = resp_status;
        result_next.nonempty  = resp_count != '0;
        result_next.top_value = (resp_count != '0) ? resp_top : '0;
        result_next.depth     = 7'(resp_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpn_pkg::SEQ_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        op_reg  <= op_next;
        if (resp_fire)
            result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign busy   = state_reg != rpn_pkg::SEQ_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
